FILE: design/jsau_pkg.sv
package jsau_pkg;

    // Parser phase
    typedef enum logic [2:0] {
        PH_PRE   = 3'd0,
        PH_ELEM  = 3'd1,
        PH_STR   = 3'd2,
        PH_ESC   = 3'd3,
        PH_HEX   = 3'd4,
        PH_AFTER = 3'd5,
        PH_DONE  = 3'd6,
        PH_ERR   = 3'd7
    } phase_t;

    // Result kind
    typedef enum logic [1:0] {
        KIND_BYTE      = 2'd0,
        KIND_STR_END   = 2'd1,
        KIND_ARRAY_END = 2'd2,
        KIND_ERROR     = 2'd3
    } kind_t;

    // Error codes
    localparam logic [3:0] ERR_EXP_ARRAY    = 4'd0;
    localparam logic [3:0] ERR_EXP_STRING   = 4'd1;
    localparam logic [3:0] ERR_TRUNC_ESC    = 4'd2;
    localparam logic [3:0] ERR_TRUNC_UNI    = 4'd3;
    localparam logic [3:0] ERR_BAD_HEX      = 4'd4;
    localparam logic [3:0] ERR_BAD_ESC      = 4'd5;
    localparam logic [3:0] ERR_UNTERM_STR   = 4'd6;
    localparam logic [3:0] ERR_EXP_COMMA    = 4'd7;
    localparam logic [3:0] ERR_UNTERM_ARRAY = 4'd8;

    // UTF-8 framing
    localparam logic [7:0] UTF8_CONT  = 8'h80;
    localparam logic [7:0] UTF8_LEAD2 = 8'hC0;
    localparam logic [7:0] UTF8_LEAD3 = 8'hE0;
    localparam logic [7:0] UTF8_MASK6 = 8'h3F;

    localparam int MAX_RESULTS = 3;

    typedef struct packed {
        phase_t      phase;
        logic        space_seen;
        logic [1:0]  digits;
        logic [15:0] acc;
        logic        hex_bad;
    } parse_state_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] value;
        logic [3:0] error_code;
        logic       last;
    } result_t;

    typedef struct packed {
        logic [1:0]                      n;
        result_t [MAX_RESULTS-1:0]       res;
    } step_out_t;

    typedef struct packed {
        logic empty;
        logic draining_last;
    } outq_status_t;

    function automatic result_t mk_result(kind_t k, logic [7:0] v, logic [3:0] e);
        result_t r;
        r.kind       = k;
        r.value      = v;
        r.error_code = e;
        r.last       = 1'b0;
        return r;
    endfunction

endpackage

FILE: design/jsau_step.sv
module jsau_step
    import jsau_pkg::*;
(
    input  parse_state_t cur,
    input  logic [7:0]   data_byte,
    input  logic         end_of_text,
    output parse_state_t nxt,
    output step_out_t    out
);

    logic        is_ws;
    logic [3:0]  hex_d;
    logic        hex_ok;
    logic [15:0] cp;
    logic        bad_now;

    always_comb
    begin
        is_ws = (data_byte == 8'd32) || (data_byte >= 8'd9 && data_byte <= 8'd13);
        hex_ok = 1'b1;
        hex_d  = 4'd0;
        if (data_byte >= "0" && data_byte <= "9")
            hex_d = 4'(data_byte - 8'h30);
        else if (data_byte >= "a" && data_byte <= "f")
            hex_d = 4'(data_byte - 8'h57);
        else if (data_byte >= "A" && data_byte <= "F")
            hex_d = 4'(data_byte - 8'h37);
        else
            hex_ok = 1'b0;
        cp      = {cur.acc[11:0], hex_d};
        bad_now = cur.hex_bad | ~hex_ok;
    end

    always_comb
    begin
        nxt       = cur;
        out.n     = 2'd0;
        out.res   = '0;

        if (end_of_text)
        begin
            out.n = 2'd1;
            unique case (cur.phase)
                PH_PRE:   out.res[0] = mk_result(KIND_ERROR, 8'd0, ERR_EXP_ARRAY);
                PH_ELEM:  out.res[0] = mk_result(KIND_ERROR, 8'd0,
                              cur.space_seen ? ERR_EXP_STRING : ERR_UNTERM_ARRAY);
                PH_STR:   out.res[0] = mk_result(KIND_ERROR, 8'd0, ERR_UNTERM_STR);
                PH_ESC:   out.res[0] = mk_result(KIND_ERROR, 8'd0, ERR_TRUNC_ESC);
                PH_HEX:   out.res[0] = mk_result(KIND_ERROR, 8'd0, ERR_TRUNC_UNI);
                PH_AFTER: out.res[0] = mk_result(KIND_ERROR, 8'd0, ERR_EXP_COMMA);
                default:  out.n = 2'd0;
            endcase
            nxt = '{phase: PH_PRE, space_seen: 1'b0, digits: 2'd0, acc: 16'd0,
                    hex_bad: 1'b0};
        end
        else
        begin
            unique case (cur.phase)
                PH_PRE:
                begin
                    if (!is_ws)
                    begin
                        if (data_byte == "[")
                        begin
                            nxt.phase      = PH_ELEM;
                            nxt.space_seen = 1'b0;
                        end
                        else
                        begin
                            nxt.phase  = PH_ERR;
                            out.n      = 2'd1;
                            out.res[0] = mk_result(KIND_ERROR, 8'd0, ERR_EXP_ARRAY);
                        end
                    end
                end
                PH_ELEM:
                begin
                    if (is_ws)
                        nxt.space_seen = 1'b1;
                    else if (data_byte == "]")
                    begin
                        nxt.phase  = PH_DONE;
                        out.n      = 2'd1;
                        out.res[0] = mk_result(KIND_ARRAY_END, 8'd0, 4'd0);
                    end
                    else if (data_byte == "\"")
                        nxt.phase = PH_STR;
                    else
                    begin
                        nxt.phase  = PH_ERR;
                        out.n      = 2'd1;
                        out.res[0] = mk_result(KIND_ERROR, 8'd0, ERR_EXP_STRING);
                    end
                end
                PH_STR:
                begin
                    if (data_byte == "\"")
                    begin
                        nxt.phase  = PH_AFTER;
                        out.n      = 2'd1;
                        out.res[0] = mk_result(KIND_STR_END, 8'd0, 4'd0);
                    end
                    else if (data_byte == "\\")
                        nxt.phase = PH_ESC;
                    else
                    begin
                        out.n      = 2'd1;
                        out.res[0] = mk_result(KIND_BYTE, data_byte, 4'd0);
                    end
                end
                PH_ESC:
                begin
                    nxt.phase = PH_STR;
                    out.n     = 2'd1;
                    case (data_byte)
                        "\"":    out.res[0] = mk_result(KIND_BYTE, 8'h22, 4'd0);
                        "\\":    out.res[0] = mk_result(KIND_BYTE, 8'h5C, 4'd0);
                        "/":     out.res[0] = mk_result(KIND_BYTE, 8'h2F, 4'd0);
                        "b":     out.res[0] = mk_result(KIND_BYTE, 8'h08, 4'd0);
                        "f":     out.res[0] = mk_result(KIND_BYTE, 8'h0C, 4'd0);
                        "n":     out.res[0] = mk_result(KIND_BYTE, 8'h0A, 4'd0);
                        "r":     out.res[0] = mk_result(KIND_BYTE, 8'h0D, 4'd0);
                        "t":     out.res[0] = mk_result(KIND_BYTE, 8'h09, 4'd0);
                        "u":
                        begin
                            out.n       = 2'd0;
                            nxt.phase   = PH_HEX;
                            nxt.digits  = 2'd0;
                            nxt.acc     = 16'd0;
                            nxt.hex_bad = 1'b0;
                        end
                        default:
                        begin
                            nxt.phase  = PH_ERR;
                            out.res[0] = mk_result(KIND_ERROR, 8'd0, ERR_BAD_ESC);
                        end
                    endcase
                end
                PH_HEX:
                begin
                    nxt.acc     = cp;
                    nxt.hex_bad = bad_now;
                    if (cur.digits != 2'd3)
                        nxt.digits = cur.digits + 2'd1;
                    else
                    begin
                        nxt.digits = 2'd0;
                        if (bad_now)
                        begin
                            nxt.phase  = PH_ERR;
                            out.n      = 2'd1;
                            out.res[0] = mk_result(KIND_ERROR, 8'd0, ERR_BAD_HEX);
                        end
                        else
                        begin
                            nxt.phase = PH_STR;
                            if (cp[15:7] == 9'd0)
                            begin
                                out.n      = 2'd1;
                                out.res[0] = mk_result(KIND_BYTE, cp[7:0], 4'd0);
                            end
                            else if (cp[15:11] == 5'd0)
                            begin
                                out.n      = 2'd2;
                                out.res[0] = mk_result(KIND_BYTE,
                                    UTF8_LEAD2 | {3'd0, cp[10:6]}, 4'd0);
                                out.res[1] = mk_result(KIND_BYTE,
                                    UTF8_CONT | (cp[7:0] & UTF8_MASK6), 4'd0);
                            end
                            else
                            begin
                                out.n      = 2'd3;
                                out.res[0] = mk_result(KIND_BYTE,
                                    UTF8_LEAD3 | {4'd0, cp[15:12]}, 4'd0);
                                out.res[1] = mk_result(KIND_BYTE,
                                    UTF8_CONT | (cp[13:6] & UTF8_MASK6), 4'd0);
                                out.res[2] = mk_result(KIND_BYTE,
                                    UTF8_CONT | (cp[7:0] & UTF8_MASK6), 4'd0);
                            end
                        end
                    end
                end
                PH_AFTER:
                begin
                    if (!is_ws)
                    begin
                        if (data_byte == ",")
                        begin
                            nxt.phase      = PH_ELEM;
                            nxt.space_seen = 1'b0;
                        end
                        else if (data_byte == "]")
                        begin
                            nxt.phase  = PH_DONE;
                            out.n      = 2'd1;
                            out.res[0] = mk_result(KIND_ARRAY_END, 8'd0, 4'd0);
                        end
                        else
                        begin
                            nxt.phase  = PH_ERR;
                            out.n      = 2'd1;
                            out.res[0] = mk_result(KIND_ERROR, 8'd0, ERR_EXP_COMMA);
                        end
                    end
                end
                default: ;
            endcase
        end

        // flag the final result of this word
        case (out.n)
            2'd1:    out.res[0].last = 1'b1;
            2'd2:    out.res[1].last = 1'b1;
            2'd3:    out.res[2].last = 1'b1;
            default: ;
        endcase
    end

endmodule

FILE: design/jsau_outq.sv
module jsau_outq
    import jsau_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       load,
    input  logic [1:0]                 load_n,
    input  result_t [MAX_RESULTS-1:0]  load_res,
    input  logic                       out_ready,
    output logic                       out_valid,
    output result_t                    head,
    output outq_status_t               status
);

    logic [1:0]                count_reg;
    logic [1:0]                count_next;
    result_t [MAX_RESULTS-1:0] slot_reg;
    result_t [MAX_RESULTS-1:0] slot_next;
    logic                      pop;

    assign out_valid            = (count_reg != 2'd0);
    assign head                 = slot_reg[0];
    assign pop                  = out_valid && out_ready;
    assign status.empty         = (count_reg == 2'd0);
    assign status.draining_last = (count_reg == 2'd1) && out_ready;

    always_comb
    begin
        count_next = count_reg;
        slot_next  = slot_reg;
        if (load)
        begin
            count_next = load_n;
            slot_next  = load_res;
        end
        else if (pop)
        begin
            // advance the queue by one result
            count_next   = count_reg - 2'd1;
            slot_next[0] = slot_reg[1];
            slot_next[1] = slot_reg[2];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= 2'd0;
        else
            count_reg <= count_next;
    end

    always_ff @(posedge clk)
    begin
        slot_reg <= slot_next;
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        load |-> (count_reg == 2'd0) || ((count_reg == 2'd1) && out_ready))
        else $error("outq: load overwrites pending results");

    assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == 2'd1) |-> slot_reg[0].last)
        else $error("outq: final queued result lacks last flag");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (head.kind != KIND_BYTE) |-> (head.value == 8'd0))
        else $error("outq: nonzero value on a non-byte result");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (head.kind != KIND_ERROR) |-> (head.error_code == 4'd0))
        else $error("outq: error code on a non-error result");

endmodule

FILE: design/json_string_array_unescaper_core.sv
// Flow: a word waits in the input register until the parser step fires, and its
//   first result is presented on the output from the edge that loads the queue.
// Throughput: one word per cycle unless the queue stalls it; a word with k results
//   holds the queue until all k are taken; a \uXXXX escape yields up to three.
// Reset (rst_n low, asynchronous): parser returns to the pre-array phase,
//   input register and output queue empty.
module json_string_array_unescaper_core
    import jsau_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] data_byte,
    input  logic       end_of_text,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [1:0] kind,
    output logic [7:0] value,
    output logic [3:0] error_code,
    output logic       last
);

    // Input register: holds one word until the parser step fires.
    logic         in_valid_reg;
    logic [7:0]   data_reg;
    logic         end_reg;

    // Parser state.
    parse_state_t state_reg;
    parse_state_t state_next;

    step_out_t    step;
    outq_status_t q_status;
    result_t      head;
    logic         fire;

    // Step output into the queue. A word without results never waits on the queue;
    // otherwise the queue must be empty or handing off its final entry this cycle.
    assign fire     = in_valid_reg &&
                      ((step.n == 2'd0) || q_status.empty || q_status.draining_last);
    assign in_ready = !in_valid_reg || fire;

    jsau_step u_step
    (
        .cur         (state_reg),
        .data_byte   (data_reg),
        .end_of_text (end_reg),
        .nxt         (state_next),
        .out         (step)
    );

    jsau_outq u_outq
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (fire && (step.n != 2'd0)),
        .load_n    (step.n),
        .load_res  (step.res),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .head      (head),
        .status    (q_status)
    );

    assign kind       = head.kind;
    assign value      = head.value;
    assign error_code = head.error_code;
    assign last       = head.last;

    // Capture a new word whenever the slot is free or drains this cycle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_valid && in_ready)
            in_valid_reg <= 1'b1;
        else if (fire)
            in_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            data_reg <= data_byte;
            end_reg  <= end_of_text;
        end
    end

    // Advance the parser only when the step's results are committed.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= '{phase: PH_PRE, space_seen: 1'b0, digits: 2'd0, acc: 16'd0,
                           hex_bad: 1'b0};
        else if (fire)
            state_reg <= state_next;
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        fire && end_reg |=> (state_reg.phase == PH_PRE))
        else $error("core: end of text did not restart the parser");

    assert property (@(posedge clk) disable iff (!rst_n)
        fire && !end_reg && ((state_reg.phase == PH_DONE) || (state_reg.phase == PH_ERR))
        |-> (step.n == 2'd0))
        else $error("core: result produced after array end or error");

    assert property (@(posedge clk) disable iff (!rst_n)
        fire && !end_reg && (step.n != 2'd0) && (step.res[0].kind == KIND_ERROR)
        |=> (state_reg.phase == PH_ERR))
        else $error("core: error reported without entering the error phase");

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import jsau_pkg::*;

    localparam int RANDOM_WORDS = 380;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 16;

    // Characters the parser cares about
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_COMMA  = 8'h2C;

    typedef struct {
        logic [7:0] data;
        logic       eot;
    } text_word_t;

    // Unescaper model plus the queue of results still owed by the block.
    class unescape_scoreboard;
        phase_t      phase;
        logic        space_seen;
        logic [1:0]  digits_taken;
        logic [15:0] code_acc;
        logic        hex_bad;
        result_t     step_q[$];
        result_t     expected_q[$];
        int          mismatch_count;

        function new();
            mismatch_count = 0;
            restart();
        endfunction

        function void restart();
            phase        = PH_PRE;
            space_seen   = 1'b0;
            digits_taken = 2'd0;
            code_acc     = 16'd0;
            hex_bad      = 1'b0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function bit is_space(logic [7:0] b);
            return b == 8'd32 || (b >= 8'd9 && b <= 8'd13);
        endfunction

        function void add(kind_t k, logic [7:0] v, logic [3:0] e);
            result_t r;
            r.kind       = k;
            r.value      = v;
            r.error_code = e;
            r.last       = 1'b0;
            step_q = {step_q, r};
        endfunction

        function void fail_with(logic [3:0] e);
            phase = PH_ERR;
            add(KIND_ERROR, 8'd0, e);
        endfunction

        // Advance the model by one accepted word and queue what it owes.
        function void note_word(logic [7:0] b, logic eot);
            logic [3:0]  digit;
            logic [15:0] cp;
            step_q.delete();
            if (eot)
            begin
                case (phase)
                    PH_PRE:   add(KIND_ERROR, 8'd0, ERR_EXP_ARRAY);
                    PH_ELEM:  add(KIND_ERROR, 8'd0,
                                  space_seen ? ERR_EXP_STRING : ERR_UNTERM_ARRAY);
                    PH_STR:   add(KIND_ERROR, 8'd0, ERR_UNTERM_STR);
                    PH_ESC:   add(KIND_ERROR, 8'd0, ERR_TRUNC_ESC);
                    PH_HEX:   add(KIND_ERROR, 8'd0, ERR_TRUNC_UNI);
                    PH_AFTER: add(KIND_ERROR, 8'd0, ERR_EXP_COMMA);
                    default: ;
                endcase
                restart();
            end
            else
            begin
                case (phase)
                    PH_PRE:
                    begin
                        if (!is_space(b))
                        begin
                            if (b == CH_LBRACK)
                            begin
                                phase      = PH_ELEM;
                                space_seen = 1'b0;
                            end
                            else
                                fail_with(ERR_EXP_ARRAY);
                        end
                    end
                    PH_ELEM:
                    begin
                        if (is_space(b))
                            space_seen = 1'b1;
                        else if (b == CH_RBRACK)
                        begin
                            phase = PH_DONE;
                            add(KIND_ARRAY_END, 8'd0, 4'd0);
                        end
                        else if (b == CH_QUOTE)
                            phase = PH_STR;
                        else
                            fail_with(ERR_EXP_STRING);
                    end
                    PH_STR:
                    begin
                        if (b == CH_QUOTE)
                        begin
                            phase = PH_AFTER;
                            add(KIND_STR_END, 8'd0, 4'd0);
                        end
                        else if (b == CH_BSLASH)
                            phase = PH_ESC;
                        else
                            add(KIND_BYTE, b, 4'd0);
                    end
                    PH_ESC:
                    begin
                        phase = PH_STR;
                        case (b)
                            CH_QUOTE:  add(KIND_BYTE, CH_QUOTE, 4'd0);
                            CH_BSLASH: add(KIND_BYTE, CH_BSLASH, 4'd0);
                            CH_SLASH:  add(KIND_BYTE, CH_SLASH, 4'd0);
                            "b":       add(KIND_BYTE, 8'h08, 4'd0);
                            "f":       add(KIND_BYTE, 8'h0C, 4'd0);
                            "n":       add(KIND_BYTE, 8'h0A, 4'd0);
                            "r":       add(KIND_BYTE, 8'h0D, 4'd0);
                            "t":       add(KIND_BYTE, 8'h09, 4'd0);
                            "u":
                            begin
                                phase        = PH_HEX;
                                digits_taken = 2'd0;
                                code_acc     = 16'd0;
                                hex_bad      = 1'b0;
                            end
                            default:   fail_with(ERR_BAD_ESC);
                        endcase
                    end
                    PH_HEX:
                    begin
                        digit = 4'd0;
                        if (b >= "0" && b <= "9")
                            digit = 4'(b - "0");
                        else if (b >= "a" && b <= "f")
                            digit = 4'(b - "a" + 8'd10);
                        else if (b >= "A" && b <= "F")
                            digit = 4'(b - "A" + 8'd10);
                        else
                            hex_bad = 1'b1;
                        code_acc = {code_acc[11:0], 4'd0} + {12'd0, digit};
                        if (digits_taken != 2'd3)
                            digits_taken++;
                        else
                        begin
                            // Fourth digit: report a bad digit only now
                            digits_taken = 2'd0;
                            if (hex_bad)
                                fail_with(ERR_BAD_HEX);
                            else
                            begin
                                phase = PH_STR;
                                cp    = code_acc;
                                if (cp < 16'h80)
                                    add(KIND_BYTE, cp[7:0], 4'd0);
                                else if (cp < 16'h800)
                                begin
                                    add(KIND_BYTE, UTF8_LEAD2 | {2'b00, cp[11:6]}, 4'd0);
                                    add(KIND_BYTE, UTF8_CONT | (cp[7:0] & UTF8_MASK6), 4'd0);
                                end
                                else
                                begin
                                    add(KIND_BYTE, UTF8_LEAD3 | {4'd0, cp[15:12]}, 4'd0);
                                    add(KIND_BYTE, UTF8_CONT | {2'b00, cp[11:6]}, 4'd0);
                                    add(KIND_BYTE, UTF8_CONT | (cp[7:0] & UTF8_MASK6), 4'd0);
                                end
                            end
                        end
                    end
                    PH_AFTER:
                    begin
                        if (!is_space(b))
                        begin
                            if (b == CH_COMMA)
                            begin
                                phase      = PH_ELEM;
                                space_seen = 1'b0;
                            end
                            else if (b == CH_RBRACK)
                            begin
                                phase = PH_DONE;
                                add(KIND_ARRAY_END, 8'd0, 4'd0);
                            end
                            else
                                fail_with(ERR_EXP_COMMA);
                        end
                    end
                    default: ;
                endcase
            end
            if (step_q.size() > 0)
                step_q[step_q.size() - 1].last = 1'b1;
            expected_q = {expected_q, step_q};
        endfunction

        function void mismatch(string field, logic [7:0] want, logic [7:0] got);
            mismatch_count++;
            $display("%0t: %s mismatch: expected %h, got %h", $time, field, want, got);
        endfunction

        function void check_result(logic [1:0] k, logic [7:0] v, logic [3:0] e, logic l);
            result_t want;
            if (expected_q.size() == 0)
            begin
                mismatch_count++;
                $display("%0t: unexpected result: expected none, got kind %h value %h code %h last %b",
                         $time, k, v, e, l);
                return;
            end
            want = expected_q.pop_front();
            if (k !== want.kind)
                mismatch("kind", {6'd0, want.kind}, {6'd0, k});
            if (v !== want.value)
                mismatch("value", want.value, v);
            if (e !== want.error_code)
                mismatch("error_code", {4'd0, want.error_code}, {4'd0, e});
            if (l !== want.last)
                mismatch("last", {7'd0, want.last}, {7'd0, l});
        endfunction
    endclass

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    logic [7:0] data_byte;
    logic       end_of_text;
    logic       out_valid;
    logic       out_ready;
    logic [1:0] kind;
    logic [7:0] value;
    logic [3:0] error_code;
    logic       last;

    unescape_scoreboard scoreboard = new();

    text_word_t word_q[$];
    bit         valid_high = 1'b0;
    int         cycle_count = 0;

    json_string_array_unescaper_core uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .data_byte   (data_byte),
        .end_of_text (end_of_text),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .kind        (kind),
        .value       (value),
        .error_code  (error_code),
        .last        (last)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // Bound the run; a hung handshake ends here.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Sample both handshakes on the edge that completes them. All drives are
    // nonblocking, so these reads see the values from before the edge.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                scoreboard.note_word(data_byte, end_of_text);
            if (out_valid && out_ready)
                scoreboard.check_result(kind, value, error_code, last);
        end
    end

    // Output backpressure: switch between stretches of always-ready, random
    // stalls and two fixed duty patterns so stalls land on every phase.
    int stall_mode = 0;
    int stall_left = 0;
    int stall_tick = 0;

    always @(posedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(20, 80);
        end
        stall_left--;
        stall_tick++;
        case (stall_mode)
            0:       out_ready <= 1'b1;
            1:       out_ready <= ($urandom_range(0, 2) != 0);
            2:       out_ready <= (stall_tick % 4 == 0);
            default: out_ready <= (stall_tick % 16 < 8);
        endcase
    end

    // ---------------------------------------------------------------
    // Text building
    // ---------------------------------------------------------------
    task automatic put_byte(logic [7:0] b);
        text_word_t w;
        w.data = b;
        w.eot  = 1'b0;
        word_q = {word_q, w};
    endtask

    task automatic put_end();
        text_word_t w;
        // Randomize the ignored byte so it can't mask a decode bug
        w.data = 8'($urandom_range(0, 255));
        w.eot  = 1'b1;
        word_q = {word_q, w};
    endtask

    task automatic put_text(string s);
        for (int i = 0; i < s.len(); i++)
            put_byte(s[i]);
    endtask

    function automatic logic [7:0] space_byte();
        logic [7:0] spaces [6] = '{8'd9, 8'd10, 8'd11, 8'd12, 8'd13, 8'd32};
        return spaces[$urandom_range(0, 5)];
    endfunction

    function automatic logic [7:0] hex_char(logic [3:0] nib, bit upper);
        if (nib < 4'd10)
            return 8'h30 + nib;
        return (upper ? 8'h41 : 8'h61) + nib - 8'd10;
    endfunction

    task automatic add_spaces(ref logic [7:0] txt[$], input int upto);
        repeat ($urandom_range(0, upto))
            txt = {txt, space_byte()};
    endtask

    // One string element: a plain byte, a short escape or a \u escape.
    // Sloppy mode sometimes breaks the escape letter or a hex digit.
    task automatic add_element(ref logic [7:0] txt[$], input bit sloppy);
        logic [7:0]  esc_letters [8] = '{CH_QUOTE, CH_BSLASH, CH_SLASH,
                                         "b", "f", "n", "r", "t"};
        int          pick;
        logic [7:0]  b;
        logic [15:0] cp;
        pick = $urandom_range(0, 9);
        if (pick < 5)
        begin
            do
                b = 8'($urandom_range(0, 255));
            while (b == CH_QUOTE || b == CH_BSLASH);
            txt = {txt, b};
        end
        else if (pick < 7)
        begin
            txt = {txt, CH_BSLASH};
            if (sloppy && $urandom_range(0, 3) == 0)
                txt = {txt, 8'($urandom_range(0, 255))};
            else
                txt = {txt, esc_letters[$urandom_range(0, 7)]};
        end
        else
        begin
            // Spread code points over the one-, two- and three-byte ranges
            case ($urandom_range(0, 2))
                0:       cp = 16'($urandom_range(16'h0000, 16'h007F));
                1:       cp = 16'($urandom_range(16'h0080, 16'h07FF));
                default: cp = 16'($urandom_range(16'h0800, 16'hFFFF));
            endcase
            txt = {txt, CH_BSLASH};
            txt = {txt, 8'h75};
            for (int i = 3; i >= 0; i--)
            begin
                if (sloppy && $urandom_range(0, 5) == 0)
                    txt = {txt, 8'($urandom_range(0, 255))};
                else
                    txt = {txt, hex_char(cp[i*4 +: 4], 1'($urandom_range(0, 1)))};
            end
        end
    endtask

    task automatic build_array(ref logic [7:0] txt[$], input bit sloppy);
        int n_str;
        n_str = $urandom_range(0, 3);
        add_spaces(txt, 2);
        txt = {txt, CH_LBRACK};
        for (int s = 0; s < n_str; s++)
        begin
            add_spaces(txt, 1);
            txt = {txt, CH_QUOTE};
            repeat ($urandom_range(0, 3))
                add_element(txt, sloppy);
            txt = {txt, CH_QUOTE};
            add_spaces(txt, 1);
            // Separator, or now and then a trailing comma before ']'
            if (s < n_str - 1 || $urandom_range(0, 3) == 0)
                txt = {txt, CH_COMMA};
        end
        add_spaces(txt, 1);
        txt = {txt, CH_RBRACK};
        // Junk after the array must be dropped
        if ($urandom_range(0, 4) == 0)
            repeat ($urandom_range(1, 3))
                txt = {txt, 8'($urandom_range(0, 255))};
    endtask

    // Mostly well-formed arrays; the rest are damaged arrays and noise.
    task automatic add_random_text();
        logic [7:0] txt[$];
        int         mode;
        int         cut;
        mode = $urandom_range(0, 99);
        if (mode < 85)
            build_array(txt, mode >= 55);
        else
        begin
            if ($urandom_range(0, 1))
                txt = {txt, CH_LBRACK};
            repeat ($urandom_range(1, 6))
                txt = {txt, 8'($urandom_range(0, 255))};
        end
        if (mode >= 55 && mode < 85 && txt.size() > 1)
        begin
            // Truncate the text or corrupt one byte of it
            if ($urandom_range(0, 1))
            begin
                cut = $urandom_range(1, txt.size() - 1);
                txt = txt[0:cut-1];
            end
            else
                txt[$urandom_range(0, txt.size() - 1)] = 8'($urandom_range(0, 255));
        end
        foreach (txt[i])
            put_byte(txt[i]);
        put_end();
    endtask

    // ---------------------------------------------------------------
    // Driving
    // ---------------------------------------------------------------

    // Present one word and hold it until the block takes it.
    task automatic send_word(text_word_t w);
        in_valid    <= 1'b1;
        data_byte   <= w.data;
        end_of_text <= w.eot;
        valid_high = 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic drop_valid();
        if (valid_high)
        begin
            in_valid <= 1'b0;
            valid_high = 1'b0;
        end
    endtask

    task automatic idle_for(int n);
        if (n > 0)
        begin
            drop_valid();
            repeat (n)
                @(posedge clk);
        end
    endtask

    // Read the owed count away from the sampling edge, then resume on a
    // rising edge.
    task automatic wait_results_drained();
        drop_valid();
        @(negedge clk);
        while (scoreboard.pending() != 0)
            @(negedge clk);
        @(posedge clk);
    endtask

    initial
    begin : stimulus
        int directed_words;
        int burst_left;

        rst_n       <= 1'b0;
        in_valid    <= 1'b0;
        data_byte   <= 8'd0;
        end_of_text <= 1'b0;

        // Directed texts:
        // end of text before anything -> expected array
        put_end();
        // end right after '[' -> unterminated array
        put_text("[");
        put_end();
        // end after '[' and whitespace -> expected string
        put_text("[\t");
        put_end();
        // bad first hex digit, reported only after the fourth; then junk in
        // the error phase and an end with no result
        put_text("[\"\\uZ000x");
        put_end();
        // end inside \u digits with a bad digit pending -> truncated unicode
        put_text("[\"\\u1z");
        put_end();
        // largest code point as three UTF-8 bytes, then end after a string
        put_text("[\"\\uFFFF\"");
        put_end();
        directed_words = word_q.size();

        while (word_q.size() < directed_words + RANDOM_WORDS)
            add_random_text();

        repeat (6)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        burst_left = 0;
        foreach (word_q[i])
        begin
            // Hold off the sender until the block has caught up, twice
            if (i == directed_words || i == word_q.size() / 2)
                wait_results_drained();
            if (burst_left == 0)
            begin
                idle_for($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6));
                burst_left = $urandom_range(1, 16);
            end
            send_word(word_q[i]);
            burst_left--;
        end

        wait_results_drained();
        repeat (DRAIN_CYCLES)
            @(posedge clk);

        if (scoreboard.mismatch_count == 0 && scoreboard.pending() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
